### rtl/assert_macros.svh
// assertion helpers for the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MPBM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("port check failed");

// next-cycle implication
`define MPBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("port check failed");

`endif

### rtl/mpbm_pkg.sv
package mpbm_pkg;

  localparam int NodeCount   = 1024;
  localparam int NodeW       = 10;
  localparam int OutsPerNode = 4;
  localparam int SlotW       = 2;
  localparam int RuleCount   = 256;
  localparam int RuleW       = 8;
  localparam int MaxPattern  = 32;
  localparam int LenW        = 6;
  localparam int PosW        = 32;
  localparam int HistW       = 33;
  localparam int ByteW       = 8;
  localparam int CntW        = 3;
  localparam int StepW       = 11;
  localparam int EdgeDepth   = NodeCount * 256;
  localparam int EdgeAw      = NodeW + ByteW;

  typedef enum logic [2:0] {
    FUNC_EDGE  = 3'd0,
    FUNC_NODE  = 3'd1,
    FUNC_OSLOT = 3'd2,
    FUNC_RULE  = 3'd3,
    FUNC_TEXT  = 3'd4,
    FUNC_END   = 3'd5
  } func_e;

  typedef struct packed {
    logic clr_we;
    logic latch;
    logic wr_exec;
    logic rd_cnt;
    logic ld_cnt;
    logic rd_orule;
    logic rd_rule;
    logic push;
    logic next_slot;
    logic flush;
    logic rd_edge;
    logic rd_fail;
    logic take_fail;
    logic force_root;
    logic adv_done;
    logic restart;
  } ctrl_cmd_t;

  typedef struct packed {
    logic  clr_done;
    func_e func;
    logic  pend_valid;
    logic  cnt_zero;
    logic  slot_last;
    logic  hit;
    logic  hold_valid;
    logic  out_free;
    logic  cur_zero;
    logic  edge_zero;
    logic  steps_max;
  } ctrl_sts_t;

  function automatic logic word_char(input logic [ByteW-1:0] c);
    word_char = (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) ||
                (c >= 8'h30 && c <= 8'h39) || (c == 8'h5f) || (c >= 8'h80);
  endfunction

endpackage

### rtl/mpbm_ram.sv
module mpbm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mpbm_ctrl.sv
module mpbm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mpbm_pkg::ctrl_sts_t sts_i,
  output mpbm_pkg::ctrl_cmd_t cmd_o
);
  import mpbm_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_CNT, S_SLOT, S_ORULE, S_RULE, S_FLUSH,
    S_ADV, S_EDGE, S_FAIL
  } state_e;

  state_e state_q, state_d;
  ctrl_cmd_t cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.latch = 1'b1;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts_i.func)
          FUNC_EDGE, FUNC_NODE, FUNC_OSLOT, FUNC_RULE: begin
            cmd.wr_exec = 1'b1;
            state_d     = S_IDLE;
          end
          FUNC_TEXT: begin
            if (sts_i.pend_valid) begin
              cmd.rd_cnt = 1'b1;
              state_d    = S_CNT;
            end else begin
              state_d = S_ADV;
            end
          end
          FUNC_END: begin
            if (sts_i.pend_valid) begin
              cmd.rd_cnt = 1'b1;
              state_d    = S_CNT;
            end else begin
              cmd.restart = 1'b1;
              state_d     = S_IDLE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_CNT: begin
        cmd.ld_cnt = 1'b1;
        state_d    = sts_i.cnt_zero ? S_FLUSH : S_SLOT;
      end
      S_SLOT: begin
        cmd.rd_orule = 1'b1;
        state_d      = S_ORULE;
      end
      S_ORULE: begin
        cmd.rd_rule = 1'b1;
        state_d     = S_RULE;
      end
      S_RULE: begin
        if (!(sts_i.hit && sts_i.hold_valid && !sts_i.out_free)) begin
          cmd.push = sts_i.hit;
          if (sts_i.slot_last) begin
            state_d = S_FLUSH;
          end else begin
            cmd.next_slot = 1'b1;
            state_d       = S_SLOT;
          end
        end
      end
      S_FLUSH: begin
        if (!(sts_i.hold_valid && !sts_i.out_free)) begin
          cmd.flush = sts_i.hold_valid;
          if (sts_i.func == FUNC_TEXT) begin
            state_d = S_ADV;
          end else begin
            cmd.restart = 1'b1;
            state_d     = S_IDLE;
          end
        end
      end
      S_ADV: begin
        cmd.rd_edge = 1'b1;
        state_d     = S_EDGE;
      end
      S_EDGE: begin
        if (!sts_i.cur_zero && sts_i.edge_zero) begin
          if (sts_i.steps_max) begin
            cmd.force_root = 1'b1;
            state_d        = S_ADV;
          end else begin
            cmd.rd_fail = 1'b1;
            state_d     = S_FAIL;
          end
        end else begin
          cmd.adv_done = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_FAIL: begin
        cmd.take_fail = 1'b1;
        state_d       = S_ADV;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o      = cmd;
  assign in_stall_o = (state_q != S_IDLE);

endmodule

### rtl/mpbm_dp.sv
module mpbm_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mpbm_pkg::ctrl_cmd_t         cmd_i,
  output mpbm_pkg::ctrl_sts_t         sts_o,
  input  logic [2:0]                  func_i,
  input  logic [mpbm_pkg::NodeW-1:0]  node_i,
  input  logic [mpbm_pkg::ByteW-1:0]  byte_value_i,
  input  logic [mpbm_pkg::NodeW-1:0]  target_i,
  input  logic [mpbm_pkg::CntW-1:0]   out_count_i,
  input  logic [mpbm_pkg::SlotW-1:0]  slot_i,
  input  logic [mpbm_pkg::RuleW-1:0]  rule_index_i,
  input  logic [mpbm_pkg::LenW-1:0]   pat_len_i,
  input  logic                        whole_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mpbm_pkg::RuleW-1:0]  match_rule_o,
  output logic [mpbm_pkg::PosW-1:0]   match_start_o,
  output logic [mpbm_pkg::PosW-1:0]   match_end_o,
  output logic                        run_last_o
);
  import mpbm_pkg::*;

  func_e              func_q;
  logic [NodeW-1:0]   node_q, target_q;
  logic [ByteW-1:0]   byte_q;
  logic [CntW-1:0]    ocnt_q;
  logic [SlotW-1:0]   slot_q;
  logic [RuleW-1:0]   ri_q;
  logic [LenW-1:0]    plen_q;
  logic               ww_q;

  logic [EdgeAw-1:0]  clr_q;
  logic [NodeW-1:0]   cur_q, pend_q;
  logic               pend_valid_q;
  logic [PosW-1:0]    pos_q;
  logic [HistW-1:0]   hist_q;
  logic [StepW-1:0]   steps_q;
  logic [CntW-1:0]    cnt_q, k_q;

  logic               hold_valid_q;
  logic [RuleW-1:0]   hold_rule_q;
  logic [PosW-1:0]    hold_start_q, hold_end_q;

  logic               out_valid_q, out_last_q;
  logic [RuleW-1:0]   out_rule_q;
  logic [PosW-1:0]    out_start_q, out_end_q;

  logic [NodeW-1:0]   edge_rd, fail_rd;
  logic [CntW-1:0]    cnt_rd;
  logic [RuleW-1:0]   orule_rd;
  logic [LenW:0]      rule_rd;

  logic               edge_we, cnt_we;
  logic [EdgeAw-1:0]  edge_waddr;
  logic [NodeW-1:0]   edge_wdata, cnt_waddr, next_cur;
  logic [CntW-1:0]    cnt_wdata, cnt_sat;
  logic [LenW-1:0]    plen_sat, len;
  logic               left_word, right_ok, out_free;

  assign cnt_sat  = (ocnt_q > CntW'(OutsPerNode)) ? CntW'(OutsPerNode) : ocnt_q;
  assign plen_sat = (plen_q > LenW'(MaxPattern)) ? LenW'(MaxPattern) : plen_q;

  assign edge_we    = cmd_i.clr_we | (cmd_i.wr_exec & (func_q == FUNC_EDGE));
  assign edge_waddr = cmd_i.clr_we ? clr_q : {node_q, byte_q};
  assign edge_wdata = cmd_i.clr_we ? '0 : target_q;
  assign cnt_we     = cmd_i.clr_we | (cmd_i.wr_exec & (func_q == FUNC_NODE));
  assign cnt_waddr  = cmd_i.clr_we ? clr_q[NodeW-1:0] : node_q;
  assign cnt_wdata  = cmd_i.clr_we ? '0 : cnt_sat;

  mpbm_ram #(.Width(NodeW), .Depth(EdgeDepth)) u_edge (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .re_i(cmd_i.rd_edge), .raddr_i({cur_q, byte_q}), .rdata_o(edge_rd)
  );

  mpbm_ram #(.Width(NodeW), .Depth(NodeCount)) u_fail (
    .clk_i, .we_i(cmd_i.wr_exec & (func_q == FUNC_NODE)), .waddr_i(node_q),
    .wdata_i(target_q), .re_i(cmd_i.rd_fail), .raddr_i(cur_q), .rdata_o(fail_rd)
  );

  mpbm_ram #(.Width(CntW), .Depth(NodeCount)) u_cnt (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .re_i(cmd_i.rd_cnt), .raddr_i(pend_q), .rdata_o(cnt_rd)
  );

  mpbm_ram #(.Width(RuleW), .Depth(NodeCount * OutsPerNode)) u_orule (
    .clk_i, .we_i(cmd_i.wr_exec & (func_q == FUNC_OSLOT)), .waddr_i({node_q, slot_q}),
    .wdata_i(ri_q), .re_i(cmd_i.rd_orule), .raddr_i({pend_q, k_q[SlotW-1:0]}),
    .rdata_o(orule_rd)
  );

  mpbm_ram #(.Width(LenW + 1), .Depth(RuleCount)) u_rule (
    .clk_i, .we_i(cmd_i.wr_exec & (func_q == FUNC_RULE)), .waddr_i(ri_q),
    .wdata_i({plen_sat, ww_q}), .re_i(cmd_i.rd_rule), .raddr_i(orule_rd),
    .rdata_o(rule_rd)
  );

  assign len       = rule_rd[LenW:1];
  assign left_word = (len <= LenW'(HistW - 1)) ? hist_q[len] : 1'b0;
  assign right_ok  = (func_q == FUNC_END) || !word_char(byte_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign next_cur  = (edge_rd == '0) ? cur_q : edge_rd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q   <= func_e'(func_i);
      node_q   <= node_i;
      byte_q   <= byte_value_i;
      target_q <= target_i;
      ocnt_q   <= out_count_i;
      slot_q   <= slot_i;
      ri_q     <= rule_index_i;
      plen_q   <= pat_len_i;
      ww_q     <= whole_word_i;
    end
    if (cmd_i.ld_cnt) begin
      cnt_q <= cnt_rd;
    end
    if (cmd_i.push) begin
      hold_rule_q  <= orule_rd;
      hold_start_q <= pos_q - {{(PosW - LenW){1'b0}}, len};
      hold_end_q   <= pos_q;
    end
    if ((cmd_i.push && hold_valid_q) || cmd_i.flush) begin
      out_rule_q  <= hold_rule_q;
      out_start_q <= hold_start_q;
      out_end_q   <= hold_end_q;
      out_last_q  <= cmd_i.flush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q        <= '0;
      cur_q        <= '0;
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
      pos_q        <= '0;
      hist_q       <= '0;
      steps_q      <= '0;
      k_q          <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.clr_we) clr_q <= clr_q + EdgeAw'(1);
      if (cmd_i.latch) begin
        steps_q <= '0;
        k_q     <= '0;
      end
      if (cmd_i.next_slot) k_q <= k_q + CntW'(1);
      if (cmd_i.rd_fail) steps_q <= steps_q + StepW'(1);
      if (cmd_i.take_fail) cur_q <= fail_rd;
      if (cmd_i.force_root) cur_q <= '0;
      if (cmd_i.adv_done) begin
        cur_q        <= next_cur;
        pend_q       <= next_cur;
        pend_valid_q <= 1'b1;
        pos_q        <= pos_q + PosW'(1);
        hist_q       <= {hist_q[HistW-2:0], word_char(byte_q)};
      end
      if (cmd_i.restart) begin
        cur_q        <= '0;
        pend_q       <= '0;
        pend_valid_q <= 1'b0;
        pos_q        <= '0;
        hist_q       <= '0;
      end
      if (cmd_i.push) hold_valid_q <= 1'b1;
      else if (cmd_i.flush) hold_valid_q <= 1'b0;
      if ((cmd_i.push && hold_valid_q) || cmd_i.flush) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.clr_done   = (clr_q == '1);
    sts_o.func       = func_q;
    sts_o.pend_valid = pend_valid_q;
    sts_o.cnt_zero   = (cnt_rd == '0);
    sts_o.slot_last  = ((k_q + CntW'(1)) >= cnt_q);
    sts_o.hit        = !rule_rd[0] || (!left_word && right_ok);
    sts_o.hold_valid = hold_valid_q;
    sts_o.out_free   = out_free;
    sts_o.cur_zero   = (cur_q == '0);
    sts_o.edge_zero  = (edge_rd == '0);
    sts_o.steps_max  = (steps_q >= StepW'(NodeCount));
  end

  assign out_valid_o   = out_valid_q;
  assign match_rule_o  = out_rule_q;
  assign match_start_o = out_start_q;
  assign match_end_o   = out_end_q;
  assign run_last_o    = out_last_q;

endmodule

### rtl/multi_pattern_byte_matcher.sv
// streaming multi-pattern byte matcher
// input channel (in_valid_i / in_stall_o): one request per table write, text byte
// or end of text, selected by func_i. output channel (out_valid_o / out_stall_i):
// one request per reported match; run_last_o marks the last match of an input.
// after reset the edge and output-count tables are swept to zero, one entry per
// cycle; in_stall_o stays high until the sweep is done.
// a table write is latched, then written. a text byte with a pending node reads
// its output count, then each match slot's rule index and rule, and flushes the
// held match; it then looks up the edge, following fail links and restarting at
// the root when the fail walk hits its step limit. end of text does the same
// held-match work; each table read is one registered memory port access.
// one request is worked on at a time; in_stall_o is high while it is in flight.
// matches of a byte are held until the next byte or end of text, then emitted.
// a stalled output keeps its result; emission then waits, nothing is lost.
// end of text flushes held matches and returns position, node and word history
// to their start values; the loaded automaton is kept.
module multi_pattern_byte_matcher (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 func_i,
  input  logic [mpbm_pkg::NodeW-1:0] node_i,
  input  logic [mpbm_pkg::ByteW-1:0] byte_value_i,
  input  logic [mpbm_pkg::NodeW-1:0] target_i,
  input  logic [mpbm_pkg::CntW-1:0]  out_count_i,
  input  logic [mpbm_pkg::SlotW-1:0] slot_i,
  input  logic [mpbm_pkg::RuleW-1:0] rule_index_i,
  input  logic [mpbm_pkg::LenW-1:0]  pat_len_i,
  input  logic                       whole_word_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [mpbm_pkg::RuleW-1:0] match_rule_o,
  output logic [mpbm_pkg::PosW-1:0]  match_start_o,
  output logic [mpbm_pkg::PosW-1:0]  match_end_o,
  output logic                       run_last_o
);
  import mpbm_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  mpbm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sts_i(sts), .cmd_o(cmd)
  );

  mpbm_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .func_i, .node_i, .byte_value_i, .target_i, .out_count_i, .slot_i,
    .rule_index_i, .pat_len_i, .whole_word_i,
    .out_valid_o, .out_stall_i, .match_rule_o, .match_start_o, .match_end_o,
    .run_last_o
  );

endmodule

### rtl/mpbm_checker.sv
`include "assert_macros.svh"

module mpbm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [mpbm_pkg::RuleW-1:0] match_rule_o,
  input logic [mpbm_pkg::PosW-1:0]  match_start_o,
  input logic [mpbm_pkg::PosW-1:0]  match_end_o,
  input logic                       run_last_o
);
  import mpbm_pkg::*;

  `MPBM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(match_rule_o) && $stable(match_end_o) && $stable(run_last_o))
  `MPBM_ASSERT_NOW(a_span, out_valid_o, (match_end_o - match_start_o) <= PosW'(MaxPattern))
  `MPBM_ASSERT_NEXT(a_one_at_a_time, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind multi_pattern_byte_matcher mpbm_checker u_mpbm_checker (.*);

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mpbm_pkg::*;

  typedef struct {
    logic [2:0]       func;
    logic [NodeW-1:0] node;
    logic [ByteW-1:0] bval;
    logic [NodeW-1:0] tgt;
    logic [CntW-1:0]  cnt;
    logic [SlotW-1:0] slot;
    logic [RuleW-1:0] rule;
    logic [LenW-1:0]  plen;
    logic             ww;
  } request_t;

  typedef struct {
    logic [RuleW-1:0] rule;
    logic [PosW-1:0]  first;
    logic [PosW-1:0]  stop;
    logic             last;
  } match_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [2:0]       func_i = '0;
  logic [NodeW-1:0] node_i = '0;
  logic [ByteW-1:0] byte_value_i = '0;
  logic [NodeW-1:0] target_i = '0;
  logic [CntW-1:0]  out_count_i = '0;
  logic [SlotW-1:0] slot_i = '0;
  logic [RuleW-1:0] rule_index_i = '0;
  logic [LenW-1:0]  pat_len_i = '0;
  logic             whole_word_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [RuleW-1:0] match_rule_o;
  logic [PosW-1:0]  match_start_o;
  logic [PosW-1:0]  match_end_o;
  logic             run_last_o;

  multi_pattern_byte_matcher dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // automaton copy
  logic [NodeW-1:0] edge_map [int];
  logic [NodeW-1:0] fail_link [NodeCount];
  logic [CntW-1:0]  node_outs [NodeCount];
  logic [RuleW-1:0] slot_rule [NodeCount*OutsPerNode];
  logic [LenW-1:0]  rule_len [RuleCount];
  logic             rule_whole [RuleCount];
  logic [NodeW-1:0] cur_node;
  logic [PosW-1:0]  text_pos;
  logic [NodeW-1:0] held_node;
  logic             held_valid;
  logic [HistW-1:0] word_hist;

  match_t expected_matches [$];
  request_t table_rows [$];
  int errors = 0;
  int accepted = 0;
  int matches_seen = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  logic hold_go = 1'b0;
  int hold_count = 0;

  function automatic void add_row(request_t q);
    table_rows.insert(table_rows.size(), q);
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           (c >= "0" && c <= "9") || c == "_" || c >= 8'h80;
  endfunction

  function automatic logic [NodeW-1:0] edge_at(logic [NodeW-1:0] nd, logic [7:0] c);
    int key;
    key = int'({nd, c});
    return edge_map.exists(key) ? edge_map[key] : '0;
  endfunction

  task automatic flush_held(logic right_ok);
    int n;
    logic [RuleW-1:0] r;
    logic [LenW-1:0] len;
    match_t m;
    n = 0;
    if (!held_valid) return;
    for (int k = 0; k < node_outs[held_node]; k++) begin
      r = slot_rule[held_node*OutsPerNode + k];
      len = rule_len[r];
      if (rule_whole[r] && (word_hist[len] || !right_ok)) continue;
      m.rule = r;
      m.first = text_pos - PosW'(len);
      m.stop = text_pos;
      m.last = 1'b0;
      expected_matches.insert(expected_matches.size(), m);
      n++;
    end
    if (n > 0) expected_matches[$].last = 1'b1;
  endtask

  task automatic predict_matches(request_t q);
    logic [NodeW-1:0] cur;
    logic [NodeW-1:0] e;
    int steps;
    case (q.func)
      FUNC_EDGE: edge_map[int'({q.node, q.bval})] = q.tgt;
      FUNC_NODE: begin
        fail_link[q.node] = q.tgt;
        node_outs[q.node] = (q.cnt > CntW'(OutsPerNode)) ? CntW'(OutsPerNode) : q.cnt;
      end
      FUNC_OSLOT: slot_rule[q.node*OutsPerNode + q.slot] = q.rule;
      FUNC_RULE: begin
        rule_len[q.rule] = (q.plen > LenW'(MaxPattern)) ? LenW'(MaxPattern) : q.plen;
        rule_whole[q.rule] = q.ww;
      end
      FUNC_TEXT: begin
        flush_held(!is_word(q.bval));
        cur = cur_node;
        steps = 0;
        while (cur != 0 && edge_at(cur, q.bval) == 0) begin
          if (steps >= NodeCount) begin
            cur = 0;
            break;
          end
          cur = fail_link[cur];
          steps++;
        end
        e = edge_at(cur, q.bval);
        if (e != 0) cur = e;
        cur_node = cur;
        text_pos = text_pos + PosW'(1);
        word_hist = {word_hist[HistW-2:0], is_word(q.bval)};
        held_node = cur;
        held_valid = 1'b1;
      end
      FUNC_END: begin
        flush_held(1'b1);
        cur_node = '0;
        text_pos = '0;
        held_node = '0;
        held_valid = 1'b0;
        word_hist = '0;
      end
      default: ;
    endcase
  endtask

  task automatic send(request_t q);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i   <= 1'b1;
    func_i       <= q.func;
    node_i       <= q.node;
    byte_value_i <= q.bval;
    target_i     <= q.tgt;
    out_count_i  <= q.cnt;
    slot_i       <= q.slot;
    rule_index_i <= q.rule;
    pat_len_i    <= q.plen;
    whole_word_i <= q.ww;
    do @(posedge clk_i); while (in_stall_o);
    predict_matches(q);
    accepted++;
  endtask

  function automatic request_t mk(logic [2:0] f, int nd, int bv, int tg, int cn, int sl,
                                  int ru, int pl, int w);
    request_t q;
    q.func = f; q.node = NodeW'(nd); q.bval = ByteW'(bv); q.tgt = NodeW'(tg);
    q.cnt = CntW'(cn); q.slot = SlotW'(sl); q.rule = RuleW'(ru); q.plen = LenW'(pl);
    q.ww = 1'(w);
    return q;
  endfunction

  function automatic request_t rnd_fields();
    return mk(3'($urandom_range(5)), $urandom_range(1023), $urandom_range(255),
              $urandom_range(1023), $urandom_range(7), $urandom_range(3),
              $urandom_range(255), $urandom_range(63), $urandom_range(1));
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return "a";
      1: return "b";
      2: return "c";
      3: return " ";
      4: return "_";
      5: return 8'hc3;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // text, ends, unused funcs; writes keep every reachable node/slot/rule defined
  function automatic request_t rnd_request();
    request_t q;
    int sel;
    q = rnd_fields();
    sel = $urandom_range(99);
    if (sel < 60) begin
      q.func = FUNC_TEXT;
      q.bval = pick_byte();
    end else if (sel < 68) begin
      q.func = FUNC_END;
    end else if (sel < 80) begin
      q.node = NodeW'($urandom_range(512, 1023));
      if (q.func == FUNC_EDGE) q.bval = pick_byte();
    end else begin
      q.func = 3'($urandom_range(3));
      q.node = NodeW'($urandom_range(3));
      q.tgt = NodeW'($urandom_range(3));
      if (q.func == FUNC_EDGE) q.bval = pick_byte();
      if (q.func == FUNC_OSLOT) q.rule = RuleW'($urandom_range(3));
      if ($urandom_range(9) == 0) q.func = 3'($urandom_range(6, 7));
    end
    return q;
  endfunction

  task automatic load_automaton();
    for (int n = 0; n < 4; n++) begin
      send(mk(FUNC_NODE, n, 0, $urandom_range(3), $urandom_range(7), 0, 0, 0, 0));
      for (int s = 0; s < OutsPerNode; s++)
        send(mk(FUNC_OSLOT, n, 0, 0, 0, s, $urandom_range(3), 0, 0));
      send(mk(FUNC_RULE, 0, 0, 0, 0, 0, n, $urandom_range(63), $urandom_range(1)));
    end
    for (int k = 0; k < 6; k++)
      send(mk(FUNC_EDGE, $urandom_range(3), pick_byte(), $urandom_range(1, 3), 0, 0, 0, 0, 0));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    match_t m;
    if (out_valid_o && !out_stall_i) begin
      matches_seen++;
      if (expected_matches.size() == 0) begin
        $display("%0t unexpected match rule %0d start %0d end %0d", $time,
                 match_rule_o, match_start_o, match_end_o);
        errors++;
      end else begin
        m = expected_matches.pop_front();
        if (m.rule !== match_rule_o || m.first !== match_start_o ||
            m.stop !== match_end_o || m.last !== run_last_o) begin
          $display("%0t mismatch exp rule %0d start %0d end %0d last %0b", $time,
                   m.rule, m.first, m.stop, m.last);
          $display("%0t          got rule %0d start %0d end %0d last %0b", $time,
                   match_rule_o, match_start_o, match_end_o, run_last_o);
          errors++;
        end
      end
    end
    if (hold_go && hold_count < 400) begin
      out_stall_i <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    cur_node = '0; text_pos = '0; held_node = '0; held_valid = 1'b0; word_hist = '0;
    foreach (node_outs[i]) node_outs[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: small automaton, saturation, whole word, end of text, unused funcs
    add_row(mk(FUNC_NODE, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_NODE, 1, 0, 0, 7, 0, 0, 0, 0));
    add_row(mk(FUNC_NODE, 2, 0, 1, 1, 0, 0, 0, 0));
    add_row(mk(FUNC_OSLOT, 1, 0, 0, 0, 0, 1, 0, 0));
    add_row(mk(FUNC_OSLOT, 1, 0, 0, 0, 1, 2, 0, 0));
    add_row(mk(FUNC_OSLOT, 1, 0, 0, 0, 2, 3, 0, 0));
    add_row(mk(FUNC_OSLOT, 1, 0, 0, 0, 3, 255, 0, 0));
    add_row(mk(FUNC_OSLOT, 2, 0, 0, 0, 0, 5, 0, 0));
    add_row(mk(FUNC_RULE, 0, 0, 0, 0, 0, 1, 1, 0));
    add_row(mk(FUNC_RULE, 0, 0, 0, 0, 0, 2, 1, 1));
    add_row(mk(FUNC_RULE, 0, 0, 0, 0, 0, 3, 63, 1));
    add_row(mk(FUNC_RULE, 0, 0, 0, 0, 0, 255, 32, 0));
    add_row(mk(FUNC_RULE, 0, 0, 0, 0, 0, 5, 2, 1));
    add_row(mk(FUNC_EDGE, 0, "a", 1, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_EDGE, 1, "b", 2, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_EDGE, 1023, 255, 1023, 7, 3, 255, 63, 1));
    add_row(mk(FUNC_TEXT, 0, "a", 0, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_TEXT, 0, "b", 0, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_TEXT, 0, " ", 0, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_TEXT, 0, "a", 0, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_END, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_TEXT, 0, "a", 0, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_TEXT, 0, 255, 0, 0, 0, 0, 0, 0));
    add_row(mk(3'd6, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(3'd7, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_END, 0, 0, 0, 0, 0, 0, 0, 0));
    foreach (table_rows[i]) send(table_rows[i]);
    drain();

    load_automaton();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; hold_go = 1'b1; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      for (int k = 0; k < 13; k++) send(rnd_request());
      send(mk(FUNC_END, 0, 0, 0, 0, 0, 0, 0, 0));
      drain();
    end

    $display("tb: %0d requests accepted, %0d matches checked over four idle/stall mixes",
             accepted, matches_seen);
    $display("tb: fail walks, whole-word boundaries, saturation and end of text exercised");
    if (errors == 0 && expected_matches.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
